/* design/page_frame_allocator_unit_macros.svh */
// Assertion helpers for the page frame allocator.
`ifndef PAGE_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_UNIT_MACROS_SVH
// Implication checked at every edge outside reset.
`define PFA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfa check failed");
// Implication checked in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfa check failed");
`endif

/* design/pfa_pkg.sv */
package pfa_pkg;
	localparam int MaxRanges = 128;
	localparam int StackDepth = 1024;
	localparam int RangeIdxW = $clog2(MaxRanges);
	localparam int RangeCntW = $clog2(MaxRanges + 1);
	localparam int StackIdxW = $clog2(StackDepth);
	localparam int StackCntW = $clog2(StackDepth + 1);
	localparam int PageW = 52;
	localparam logic [PageW-1:0] PageMax = {PageW{1'b1}};

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_FREE = 2'd2,
		CMD_CHECK = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_OOM = 2'd1,
		ST_IGNORED = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC_RD,
		S_ALLOC_CMP,
		S_POP_RD,
		S_POP_DONE,
		S_CHK_RANGE_RD,
		S_CHK_RANGE_CMP,
		S_CHK_STACK_RD,
		S_CHK_STACK_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [63:0] address;
		logic [63:0] region_length;
		logic region_usable;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [63:0] page_address;
		logic is_allocated;
		logic [PageW-1:0] free_pages;
		logic [PageW-1:0] used_pages;
		logic [PageW-1:0] total_pages;
	} rsp_t;

	// Saturating add at 52 bits.
	function automatic logic [PageW-1:0] sat_add(input logic [PageW-1:0] a,
			input logic [PageW-1:0] b);
		logic [PageW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[PageW] ? PageMax : s[PageW-1:0];
	endfunction
endpackage

/* design/pfa_stream_if.sv */
interface pfa_stream_if #(parameter type payload_t = logic);
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/pfa_range_table.sv */
// Range table: start, end and cursor in one registered-read memory.
module pfa_range_table (
	input logic clk,
	input logic we,
	input logic [pfa_pkg::RangeIdxW-1:0] waddr,
	input logic [3*pfa_pkg::PageW-1:0] wdata,
	input logic [pfa_pkg::RangeIdxW-1:0] raddr,
	output logic [3*pfa_pkg::PageW-1:0] rdata
);
	import pfa_pkg::*;
	logic [3*PageW-1:0] mem_q [MaxRanges];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* design/pfa_free_stack.sv */
// Free stack storage, one write and one registered read port.
module pfa_free_stack (
	input logic clk,
	input logic we,
	input logic [pfa_pkg::StackIdxW-1:0] waddr,
	input logic [pfa_pkg::PageW-1:0] wdata,
	input logic [pfa_pkg::StackIdxW-1:0] raddr,
	output logic [pfa_pkg::PageW-1:0] rdata
);
	import pfa_pkg::*;
	logic [PageW-1:0] mem_q [StackDepth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* design/page_frame_allocator_unit.sv */
// Page frame allocator, one word in flight at a time.
// Add and free finish directly; allocate pops the free stack, else steps through the stored ranges.
// Check walks the stored ranges, then compares the stacked pages when needed.
// Result held in an output register; next word taken the cycle after the result leaves,
// so a new word is not taken while the previous one is in flight or its result waits.
// arst_n clears counters, fills, the sequencer, the result and the offset; memories are not cleared.
module page_frame_allocator_unit (
	input logic clk,
	input logic arst_n,
	pfa_stream_if.sink in_ch,
	pfa_stream_if.source out_ch,
	input logic cfg_we,
	input logic [63:0] cfg_wdata
);
	import pfa_pkg::*;
`include "page_frame_allocator_unit_macros.svh"

	state_t state_q, state_d;
	req_t req_q;
	logic [63:0] offset_q;
	logic [RangeCntW-1:0] ranges_q;
	logic [RangeCntW-1:0] cur_q;
	logic [StackCntW-1:0] fill_q;
	logic [PageW-1:0] free_q, used_q, total_q;
	logic [RangeCntW-1:0] scan_r_q; // walk index over ranges
	logic [StackCntW-1:0] scan_s_q; // walk index over stack
	status_t status_q;
	logic [63:0] page_q;
	logic alloc_q;
	logic out_valid_q;

	// memories
	logic rt_we;
	logic [RangeIdxW-1:0] rt_waddr, rt_raddr;
	logic [3*PageW-1:0] rt_wdata, rt_rdata;
	logic fs_we;
	logic [StackIdxW-1:0] fs_waddr, fs_raddr;
	logic [PageW-1:0] fs_wdata, fs_rdata;

	pfa_range_table u_rt (.clk, .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata),
		.raddr(rt_raddr), .rdata(rt_rdata));
	pfa_free_stack u_fs (.clk, .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
		.raddr(fs_raddr), .rdata(fs_rdata));

	logic [PageW-1:0] r_start, r_end, r_cur;
	assign r_start = rt_rdata[3*PageW-1:2*PageW];
	assign r_end = rt_rdata[2*PageW-1:PageW];
	assign r_cur = rt_rdata[PageW-1:0];

	// add region alignment
	logic [63:0] a_start, a_end, a_pages;
	logic add_ok;
	assign a_start = (req_q.address + 64'd4095) & ~64'd4095;
	assign a_end = (req_q.address + req_q.region_length) & ~64'd4095;
	assign add_ok = req_q.region_usable && (a_end > a_start);
	assign a_pages = (a_end - a_start) >> 12;

	// check page number
	logic [63:0] chk_va;
	logic [PageW-1:0] chk_pg;
	assign chk_va = req_q.address - offset_q;
	assign chk_pg = chk_va[63:12];
	logic in_range, cur_ok;
	assign in_range = (chk_pg >= r_start) && (chk_pg < r_end);
	assign cur_ok = r_cur < r_end;

	logic accept;
	assign accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	// counters only move while no result is waiting, so they are read live
	assign out_ch.data = {status_q, page_q, alloc_q, free_q, used_q, total_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_DONE;
					if (in_ch.data.cmd == CMD_ALLOC) begin
						state_d = S_ALLOC_RD;
					end else if (in_ch.data.cmd == CMD_CHECK) begin
						state_d = S_CHK_RANGE_RD;
					end
				end
			end
			S_ALLOC_RD: begin
				if (fill_q != '0) begin
					state_d = S_POP_RD;
				end else if (cur_q >= ranges_q) begin
					state_d = S_DONE;
				end else begin
					state_d = S_ALLOC_CMP;
				end
			end
			S_ALLOC_CMP: state_d = cur_ok ? S_DONE : S_ALLOC_RD;
			S_POP_RD: state_d = S_POP_DONE;
			S_POP_DONE: state_d = S_DONE;
			S_CHK_RANGE_RD: begin
				if (req_q.address == '0) begin
					state_d = S_DONE;
				end else if (scan_r_q >= ranges_q) begin
					state_d = S_CHK_STACK_RD;
				end else begin
					state_d = S_CHK_RANGE_CMP;
				end
			end
			S_CHK_RANGE_CMP: begin
				if (!in_range) begin
					state_d = S_CHK_RANGE_RD;
				end else if (chk_pg >= r_cur) begin
					state_d = S_DONE;
				end else begin
					state_d = S_CHK_STACK_RD;
				end
			end
			S_CHK_STACK_RD: begin
				if (req_q.address[11:0] != '0 || scan_s_q >= fill_q) begin
					state_d = S_DONE;
				end else begin
					state_d = S_CHK_STACK_CMP;
				end
			end
			S_CHK_STACK_CMP: state_d = (fs_rdata == req_q.address[63:12]) ? S_DONE :
				S_CHK_STACK_RD;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rt_raddr = (state_q == S_ALLOC_RD) ? cur_q[RangeIdxW-1:0] : scan_r_q[RangeIdxW-1:0];
		rt_we = 1'b0;
		rt_waddr = cur_q[RangeIdxW-1:0];
		rt_wdata = {r_start, r_end, r_cur + 1'b1};
		if (state_q == S_DONE && req_q.cmd == CMD_ADD && add_ok && ranges_q < MaxRanges) begin
			rt_we = 1'b1;
			rt_waddr = ranges_q[RangeIdxW-1:0];
			rt_wdata = {a_start[63:12], a_end[63:12], a_start[63:12]};
		end else if (state_q == S_ALLOC_CMP && cur_ok) begin
			rt_we = 1'b1;
		end
		fs_waddr = (state_q == S_POP_RD) ? StackIdxW'(fill_q - 1'b1) : fill_q[StackIdxW-1:0];
		fs_raddr = (state_q == S_POP_RD) ? fs_waddr : scan_s_q[StackIdxW-1:0];
		fs_wdata = req_q.address[63:12];
		fs_we = state_q == S_DONE && req_q.cmd == CMD_FREE && req_q.address != '0 &&
			req_q.address[11:0] == '0 && fill_q < StackDepth;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			offset_q <= '0;
			ranges_q <= '0;
			cur_q <= '0;
			fill_q <= '0;
			free_q <= '0;
			used_q <= '0;
			total_q <= '0;
			out_valid_q <= 1'b0;
			scan_r_q <= '0;
			scan_s_q <= '0;
			status_q <= ST_OK;
			page_q <= '0;
			alloc_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				offset_q <= cfg_wdata;
			end
			if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				scan_r_q <= '0;
				scan_s_q <= '0;
				status_q <= ST_OK;
				page_q <= '0;
				alloc_q <= 1'b0;
			end
			case (state_q)
				S_ALLOC_RD: begin
					if (fill_q == '0 && cur_q >= ranges_q) begin
						status_q <= ST_OOM;
					end
				end
				S_ALLOC_CMP: begin
					if (cur_ok) begin
						page_q <= {r_cur, 12'd0} + offset_q;
						free_q <= (free_q != '0) ? free_q - 1'b1 : free_q;
						used_q <= sat_add(used_q, PageW'(1));
					end else begin
						cur_q <= cur_q + 1'b1;
					end
				end
				S_POP_RD: fill_q <= fill_q - 1'b1;
				S_POP_DONE: begin
					page_q <= {fs_rdata, 12'd0};
					free_q <= (free_q != '0) ? free_q - 1'b1 : free_q;
					used_q <= sat_add(used_q, PageW'(1));
				end
				S_CHK_RANGE_RD: begin
					// null address answers 0 without a walk
					if (req_q.address != '0 && scan_r_q >= ranges_q) begin
						alloc_q <= 1'b1;
					end
				end
				S_CHK_RANGE_CMP: begin
					scan_r_q <= scan_r_q + 1'b1;
					if (in_range) begin
						alloc_q <= chk_pg < r_cur;
					end
				end
				S_CHK_STACK_CMP: begin
					scan_s_q <= scan_s_q + 1'b1;
					if (fs_rdata == req_q.address[63:12]) begin
						alloc_q <= 1'b0;
					end
				end
				S_DONE: begin
					out_valid_q <= 1'b1;
					if (req_q.cmd == CMD_ADD) begin
						if (!add_ok) begin
							status_q <= ST_IGNORED;
						end else begin
							total_q <= sat_add(total_q, a_pages[PageW-1:0] |
								{PageW{a_pages[63:PageW] != '0}});
							free_q <= sat_add(free_q, a_pages[PageW-1:0] |
								{PageW{a_pages[63:PageW] != '0}});
							if (ranges_q < MaxRanges) begin
								ranges_q <= ranges_q + 1'b1;
							end
						end
					end else if (req_q.cmd == CMD_FREE) begin
						if (req_q.address == '0 || req_q.address[11:0] != '0) begin
							status_q <= ST_IGNORED;
						end else if (fill_q >= StackDepth) begin
							status_q <= ST_OVERFLOW;
						end else begin
							fill_q <= fill_q + 1'b1;
							free_q <= sat_add(free_q, PageW'(1));
							used_q <= (used_q != '0) ? used_q - 1'b1 : used_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_ch.data;
		end
	end

	`PFA_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= StackDepth)
	`PFA_ASSERT_IMP(a_ranges_bound, 1'b1, ranges_q <= MaxRanges)
	`PFA_ASSERT_IMP(a_no_accept_busy, state_q != S_IDLE, !accept)
	`PFA_ASSERT_NEXT(a_done_valid, state_q == S_DONE, out_valid_q)
endmodule
